### rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Types and constants shared by the defragmentation tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wdt_pkg;

  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;
  localparam int unsigned SeqW       = 12;
  localparam int unsigned FragW      = 4;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned HdrLenW    = 6;
  localparam int unsigned FrameLenW  = 12;
  localparam int unsigned LenW       = 16;
  localparam int unsigned TicksW     = 16;

  localparam logic [TicksW-1:0] TimeoutReset = 16'd2000;
  localparam logic [LenW-1:0]   LenMax       = 16'hFFFF;

  typedef enum logic {
    OP_FRAG = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_PASS      = 3'd0,
    STAT_ABSORBED  = 3'd1,
    STAT_COMPLETE  = 3'd2,
    STAT_BAD_HDR   = 3'd3,
    STAT_NOT_FIRST = 3'd4,
    STAT_MIC_FAIL  = 3'd5,
    STAT_TICK_IDLE = 3'd6,
    STAT_TIMEOUT   = 3'd7
  } status_e;

  typedef enum logic {
    REG_TIMEOUT_TICKS = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_e;

  typedef struct packed {
    op_e                  operation;
    logic [SeqW-1:0]      seq_num;
    logic [FragW-1:0]     frag_no;
    logic                 more_frag;
    logic [AddrW-1:0]     addr_one;
    logic [AddrW-1:0]     addr_two;
    logic [HdrLenW-1:0]   header_len;
    logic [FrameLenW-1:0] frame_len;
    logic                 pn_abnormal;
    logic                 mic_ok;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic            flushed_previous;
    logic [LenW-1:0] total_len;
  } out_item_t;

  typedef struct packed {
    logic              active;
    logic [TicksW-1:0] time_left;
  } ctx_stat_t;

endpackage

`default_nettype wire

### rtl/wdt_in_if.sv
// ----------------------------------------------------------------------------
// wdt_in_if
// Input channel: fragment headers and timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface wdt_in_if;
  logic              valid;
  logic              ready;
  wdt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/wdt_out_if.sv
// ----------------------------------------------------------------------------
// wdt_out_if
// Result channel: one status item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wdt_out_if;
  logic               valid;
  logic               ready;
  wdt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/wlan_defragment_tracker.sv
// ----------------------------------------------------------------------------
// wlan_defragment_tracker
// Tracks 802.11 fragment reassembly for one peer, with an inactivity timeout.
// ----------------------------------------------------------------------------
//  Port          Dir   Handshake                 Payload
//  frag_chan_i   in    valid/ready               fragment header or timer tick
//  res_chan_o    out   valid/ready               status, flush flag, length
//  APB           in    psel/penable/pwrite/pready timeout_ticks at address 0
//
//  Each item waits in the input register and then moves to the result
//  register; one item is accepted every cycle unless the result side
//  stalls. The context registers update as an item enters the result
//  register. A stalled result holds the input register; the input side
//  stalls only when both registers are full. Reset is asynchronous and
//  needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wlan_defragment_tracker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  wdt_in_if.sink                          frag_chan_i,
  wdt_out_if.source                       res_chan_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wdt_pkg::PaddrW-1:0] paddr,
  input  wire logic [wdt_pkg::PdataW-1:0] pwdata,
  output logic      [wdt_pkg::PdataW-1:0] prdata,
  output logic                            pready
);

  logic                       in_valid_q;
  wdt_pkg::in_item_t          in_item_q;
  logic                       res_valid_q;
  wdt_pkg::out_item_t         res_q;
  logic                       res_free;
  logic                       advance;
  wdt_pkg::out_item_t         res_d;
  wdt_pkg::ctx_stat_t         ctx_stat;
  logic [wdt_pkg::TicksW-1:0] timeout_ticks;

  wdt_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .timeout_ticks_o (timeout_ticks)
  );

  wdt_ctx u_ctx (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .item_i          (in_item_q),
    .timeout_ticks_i (timeout_ticks),
    .result_o        (res_d),
    .stat_o          (ctx_stat)
  );

  assign res_free          = !res_valid_q || res_chan_o.ready;
  assign advance           = in_valid_q && res_free;
  assign frag_chan_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (frag_chan_i.ready) begin
        in_valid_q <= frag_chan_i.valid;
      end
      if (res_free) begin
        res_valid_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frag_chan_i.valid && frag_chan_i.ready) begin
      in_item_q <= frag_chan_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_chan_o.valid   = res_valid_q;
  assign res_chan_o.payload = res_q;

`ifndef SYNTHESIS
  a_complete_not_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == wdt_pkg::STAT_COMPLETE)) |-> !res_q.flushed_previous)
    else $error("completed reassembly reported a flush");

  a_tick_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && ((res_q.status == wdt_pkg::STAT_TICK_IDLE) ||
                     (res_q.status == wdt_pkg::STAT_TIMEOUT)))
    |-> ((res_q.total_len == '0) && !res_q.flushed_previous))
    else $error("tick result carries a length or flush flag");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.status == wdt_pkg::STAT_TIMEOUT)) |=> !ctx_stat.active)
    else $error("context still active after timeout flush");

  a_absorb_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.status == wdt_pkg::STAT_ABSORBED)) |=> ctx_stat.active)
    else $error("absorbed fragment left no active context");
`endif

endmodule

`default_nettype wire

### rtl/wdt_apb_regs.sv
// ----------------------------------------------------------------------------
// wdt_apb_regs
// APB register file holding the inactivity timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module wdt_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wdt_pkg::PaddrW-1:0]  paddr,
  input  wire logic [wdt_pkg::PdataW-1:0]  pwdata,
  output logic      [wdt_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  output logic      [wdt_pkg::TicksW-1:0]  timeout_ticks_o
);

  logic [wdt_pkg::TicksW-1:0] timeout_q;
  logic [wdt_pkg::TicksW-1:0] timeout_d;
  wdt_pkg::reg_idx_e          reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = wdt_pkg::reg_idx_e'(paddr[wdt_pkg::PaddrW-1]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en && (reg_idx == wdt_pkg::REG_TIMEOUT_TICKS)) begin
      timeout_d = pwdata[wdt_pkg::TicksW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= wdt_pkg::TimeoutReset;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      wdt_pkg::REG_TIMEOUT_TICKS: begin
        prdata = {{(wdt_pkg::PdataW - wdt_pkg::TicksW){1'b0}}, timeout_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign timeout_ticks_o = timeout_q;

endmodule

`default_nettype wire

### rtl/wdt_ctx.sv
// ----------------------------------------------------------------------------
// wdt_ctx
// Reassembly context and the per-item decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module wdt_ctx (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire wdt_pkg::in_item_t          item_i,
  input  wire logic [wdt_pkg::TicksW-1:0] timeout_ticks_i,
  output wdt_pkg::out_item_t              result_o,
  output wdt_pkg::ctx_stat_t              stat_o
);

  logic                          active_q, active_d;
  logic [wdt_pkg::SeqW-1:0]      last_seq_q, last_seq_d;
  logic [wdt_pkg::FragW-1:0]     last_frag_q, last_frag_d;
  logic [wdt_pkg::AddrW-1:0]     addr_one_q, addr_one_d;
  logic [wdt_pkg::AddrW-1:0]     addr_two_q, addr_two_d;
  logic [wdt_pkg::LenW-1:0]      accum_len_q, accum_len_d;
  logic [wdt_pkg::TicksW-1:0]    time_left_q, time_left_d;

  logic                          mismatch;
  logic                          frag_next_ok;
  logic [wdt_pkg::FrameLenW-1:0] hlen_ext;
  logic [wdt_pkg::FrameLenW-1:0] body;
  logic [wdt_pkg::LenW:0]        sum;
  logic [wdt_pkg::LenW-1:0]      sum_sat;
  logic                          single;

  assign frag_next_ok = ({1'b0, item_i.frag_no} == ({1'b0, last_frag_q} + 5'd1));
  assign mismatch     = active_q && ((item_i.seq_num != last_seq_q) || !frag_next_ok ||
                                     (item_i.addr_one != addr_one_q) ||
                                     (item_i.addr_two != addr_two_q) ||
                                     item_i.pn_abnormal);
  assign hlen_ext     = {{(wdt_pkg::FrameLenW - wdt_pkg::HdrLenW){1'b0}}, item_i.header_len};
  assign body         = (item_i.frame_len > hlen_ext) ? (item_i.frame_len - hlen_ext) : '0;
  assign sum          = {1'b0, accum_len_q} +
                        {{(wdt_pkg::LenW + 1 - wdt_pkg::FrameLenW){1'b0}}, body};
  assign sum_sat      = sum[wdt_pkg::LenW] ? wdt_pkg::LenMax : sum[wdt_pkg::LenW-1:0];
  assign single       = !item_i.more_frag && (item_i.frag_no == '0);

  always_comb begin
    active_d    = active_q;
    last_seq_d  = last_seq_q;
    last_frag_d = last_frag_q;
    addr_one_d  = addr_one_q;
    addr_two_d  = addr_two_q;
    accum_len_d = accum_len_q;
    time_left_d = time_left_q;

    result_o.status           = wdt_pkg::STAT_PASS;
    result_o.flushed_previous = 1'b0;
    result_o.total_len        = {{(wdt_pkg::LenW - wdt_pkg::FrameLenW){1'b0}}, item_i.frame_len};

    priority if (item_i.operation == wdt_pkg::OP_TICK) begin
      result_o.total_len = '0;
      if (active_q && (time_left_q[wdt_pkg::TicksW-1:1] == '0)) begin
        active_d        = 1'b0;
        time_left_d     = '0;
        result_o.status = wdt_pkg::STAT_TIMEOUT;
      end else begin
        if (active_q) begin
          time_left_d = time_left_q - 16'd1;
        end
        result_o.status = wdt_pkg::STAT_TICK_IDLE;
      end
    end else if (item_i.header_len == '0) begin
      result_o.status = wdt_pkg::STAT_BAD_HDR;
    end else if (single && !active_q) begin
      result_o.status = wdt_pkg::STAT_PASS;
    end else if (!active_q || mismatch) begin
      result_o.flushed_previous = mismatch;
      active_d    = 1'b0;
      time_left_d = '0;
      if (single) begin
        result_o.status = wdt_pkg::STAT_PASS;
      end else if (item_i.frag_no != '0) begin
        result_o.status = wdt_pkg::STAT_NOT_FIRST;
      end else begin
        active_d        = 1'b1;
        last_seq_d      = item_i.seq_num;
        last_frag_d     = item_i.frag_no;
        addr_one_d      = item_i.addr_one;
        addr_two_d      = item_i.addr_two;
        accum_len_d     = {{(wdt_pkg::LenW - wdt_pkg::FrameLenW){1'b0}}, item_i.frame_len};
        time_left_d     = timeout_ticks_i;
        result_o.status = wdt_pkg::STAT_ABSORBED;
      end
    end else begin
      accum_len_d = sum_sat;
      last_seq_d  = item_i.seq_num;
      last_frag_d = item_i.frag_no;
      time_left_d = timeout_ticks_i;
      if (item_i.more_frag) begin
        result_o.status = wdt_pkg::STAT_ABSORBED;
      end else begin
        active_d    = 1'b0;
        time_left_d = '0;
        if (item_i.mic_ok) begin
          result_o.status    = wdt_pkg::STAT_COMPLETE;
          result_o.total_len = sum_sat;
        end else begin
          result_o.status = wdt_pkg::STAT_MIC_FAIL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      last_seq_q  <= '0;
      last_frag_q <= '0;
      addr_one_q  <= '0;
      addr_two_q  <= '0;
      accum_len_q <= '0;
      time_left_q <= '0;
    end else if (step_i) begin
      active_q    <= active_d;
      last_seq_q  <= last_seq_d;
      last_frag_q <= last_frag_d;
      addr_one_q  <= addr_one_d;
      addr_two_q  <= addr_two_d;
      accum_len_q <= accum_len_d;
      time_left_q <= time_left_d;
    end
  end

  assign stat_o.active    = active_q;
  assign stat_o.time_left = time_left_q;

endmodule

`default_nettype wire

### dv/tb_wlan_defragment_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wlan_defragment_tracker
// Self-checking bench for the fragment reassembly tracker. A scoreboard keeps
// its own copy of the reassembly context and the timeout register. From each
// accepted fragment or tick it predicts the status item. Each result item is
// compared field by field in order. A short directed run covers every status
// code and every flush cause. Randomized reassembly chains, tick runs and
// noise then run under several timeout settings, with bursty input and a
// stalling result side.
// ----------------------------------------------------------------------------

module tb_wlan_defragment_tracker;
  import wdt_pkg::*;

  localparam int unsigned ItemsPerPhase = 192;

  class defrag_scoreboard;
    logic [TicksW-1:0] timeout_ticks;
    logic              active;
    logic [SeqW-1:0]   last_seq;
    logic [FragW-1:0]  last_frag;
    logic [AddrW-1:0]  addr_one_q;
    logic [AddrW-1:0]  addr_two_q;
    logic [LenW-1:0]   accum_len;
    logic [TicksW-1:0] time_left;
    out_item_t         expected_status_q[$];
    int unsigned       errors;

    function new();
      timeout_ticks = TimeoutReset;
      active = 1'b0;
      last_seq = '0;
      last_frag = '0;
      addr_one_q = '0;
      addr_two_q = '0;
      accum_len = '0;
      time_left = '0;
      errors = 0;
    endfunction

    function void set_timeout(logic [TicksW-1:0] ticks);
      timeout_ticks = ticks;
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction

    function void drop_context();
      active = 1'b0;
      time_left = '0;
    endfunction

    function void record_arrival(in_item_t it);
      out_item_t            res;
      logic [FrameLenW-1:0] body;
      logic [LenW:0]        sum;
      res.status = STAT_TICK_IDLE;
      res.flushed_previous = 1'b0;
      res.total_len = LenW'(it.frame_len);
      if (it.operation == OP_TICK) begin
        res.total_len = '0;
        if (active && time_left <= 1) begin
          drop_context();
          res.status = STAT_TIMEOUT;
        end else begin
          if (active) time_left = time_left - 1'b1;
          res.status = STAT_TICK_IDLE;
        end
      end else if (it.header_len == '0) begin
        res.status = STAT_BAD_HDR;
      end else if (!it.more_frag && it.frag_no == '0 && !active) begin
        res.status = STAT_PASS;
      end else begin
        if (active) begin
          time_left = timeout_ticks;
          if (it.seq_num != last_seq || {1'b0, it.frag_no} != {1'b0, last_frag} + 5'd1 ||
              it.addr_one != addr_one_q || it.addr_two != addr_two_q || it.pn_abnormal) begin
            drop_context();
            res.flushed_previous = 1'b1;
          end
        end
        if (!active) begin
          if (!it.more_frag && it.frag_no == '0) begin
            res.status = STAT_PASS;
          end else if (it.frag_no != '0) begin
            res.status = STAT_NOT_FIRST;
          end else begin
            active = 1'b1;
            last_seq = it.seq_num;
            last_frag = it.frag_no;
            addr_one_q = it.addr_one;
            addr_two_q = it.addr_two;
            accum_len = LenW'(it.frame_len);
            time_left = timeout_ticks;
            res.status = STAT_ABSORBED;
          end
        end else begin
          body = (it.frame_len > it.header_len) ? it.frame_len - it.header_len : '0;
          sum = accum_len + body;
          accum_len = (sum > LenMax) ? LenMax : sum[LenW-1:0];
          last_seq = it.seq_num;
          last_frag = it.frag_no;
          if (it.more_frag) begin
            res.status = STAT_ABSORBED;
          end else begin
            drop_context();
            if (it.mic_ok) begin
              res.status = STAT_COMPLETE;
              res.total_len = accum_len;
            end else begin
              res.status = STAT_MIC_FAIL;
            end
          end
        end
      end
      expected_status_q.push_back(res);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status_q.size() == 0) begin
        $error("result item with nothing expected: status %0d total_len %0d",
               got.status, got.total_len);
        errors++;
        return;
      end
      want = expected_status_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.flushed_previous !== want.flushed_previous) begin
        $error("flushed_previous: expected %0d, actual %0d",
               want.flushed_previous, got.flushed_previous);
        errors++;
      end
      if (got.total_len !== want.total_len) begin
        $error("total_len: expected %0d, actual %0d", want.total_len, got.total_len);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic pready;

  wdt_in_if  frag_if ();
  wdt_out_if res_if ();

  defrag_scoreboard  sb = new();
  int unsigned       items_sent;
  int unsigned       burst_left;
  logic [TicksW-1:0] cur_timeout;

  wlan_defragment_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .frag_chan_i (frag_if),
    .res_chan_o  (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (frag_if.valid && frag_if.ready) sb.record_arrival(frag_if.payload);
      if (res_if.valid && res_if.ready) sb.check_status(res_if.payload);
    end
  end

  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned beat;
    res_if.ready = 1'b0;
    mode = 0;
    left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      beat++;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 3) != 0);
        2: res_if.ready <= ((beat % 7) < 3);
        default: res_if.ready <= ((beat % 13) == 0);
      endcase
    end
  end

  function automatic logic [AddrW-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[AddrW-1:0];
  endfunction

  function automatic in_item_t frag_item(logic [SeqW-1:0] seq, logic [FragW-1:0] frag,
                                         logic more, logic [AddrW-1:0] a1,
                                         logic [AddrW-1:0] a2, logic [HdrLenW-1:0] hlen,
                                         logic [FrameLenW-1:0] flen, logic pn, logic mic);
    in_item_t it;
    it.operation = OP_FRAG;
    it.seq_num = seq;
    it.frag_no = frag;
    it.more_frag = more;
    it.addr_one = a1;
    it.addr_two = a2;
    it.header_len = hlen;
    it.frame_len = flen;
    it.pn_abnormal = pn;
    it.mic_ok = mic;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return frag_item(SeqW'($urandom), FragW'($urandom), 1'($urandom), rand48(), rand48(),
                     HdrLenW'($urandom), FrameLenW'($urandom), 1'($urandom),
                     1'($urandom));
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = noise_item();
    it.operation = OP_TICK;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        frag_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    frag_if.valid <= 1'b1;
    frag_if.payload <= it;
    do @(posedge clk); while (frag_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic wait_drained();
    frag_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TicksW-1:0] ticks);
    logic [15:0] junk;
    junk = 16'($urandom);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TIMEOUT_TICKS, 2'b00};
    pwdata <= {junk, ticks};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_timeout(ticks);
    cur_timeout = ticks;
  endtask

  // Mostly well-formed reassembly chains with random content, some with corrupted
  // fragments; the rest are tick runs that can straddle a short timeout, and noise.
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    int unsigned span;
    in_item_t it;
    logic [SeqW-1:0] seq;
    logic [AddrW-1:0] a1;
    logic [AddrW-1:0] a2;
    stop_at = items_sent + count;
    span = (cur_timeout < 8) ? cur_timeout + 2 : 3;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        len = (pick < 80) ? $urandom_range(1, 4) :
              (pick < 95) ? $urandom_range(5, 12) : $urandom_range(15, 17);
        seq = SeqW'($urandom);
        a1 = rand48();
        a2 = rand48();
        for (int unsigned k = 0; k < len; k++) begin
          it = frag_item(seq, FragW'(k), k + 1 < len, a1, a2,
                         HdrLenW'(($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, 63)),
                         FrameLenW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) :
                                                                  $urandom_range(0, 4095)),
                         $urandom_range(0, 99) < 3, $urandom_range(0, 99) < 85);
          if ($urandom_range(0, 99) < 5) begin
            case ($urandom_range(0, 3))
              0: it.seq_num = it.seq_num ^ (SeqW'(1) << $urandom_range(0, SeqW - 1));
              1: it.frag_no = FragW'($urandom);
              2: it.addr_one = it.addr_one ^ (AddrW'(1) << $urandom_range(0, AddrW - 1));
              default: it.addr_two = it.addr_two ^ (AddrW'(1) << $urandom_range(0, AddrW - 1));
            endcase
          end
          send_item(it);
          if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, span)) send_item(tick_item());
          end
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, span)) send_item(tick_item());
      end else begin
        it = noise_item();
        it.operation = op_e'($urandom_range(0, 1));
        send_item(it);
      end
    end
  endtask

  initial begin
    logic [AddrW-1:0]  a;
    logic [AddrW-1:0]  b;
    logic [TicksW-1:0] phase_timeouts[6];
    frag_if.valid = 1'b0;
    frag_if.payload = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    burst_left = 0;
    cur_timeout = TimeoutReset;
    a = rand48();
    b = rand48();
    wait (rst_n === 1'b1);
    @(posedge clk);

    send_item(frag_item(12'd0, 4'd0, 1'b0, a, b, 6'd0, 12'd4095, 1'b0, 1'b1));
    send_item(frag_item(12'd0, 4'd0, 1'b0, '0, '0, 6'd1, 12'd0, 1'b0, 1'b0));
    send_item(tick_item());
    send_item(frag_item(12'd4095, 4'd0, 1'b1, '1, '1, 6'd63, 12'd4095, 1'b0, 1'b0));
    send_item(tick_item());
    // Header longer than the fragment: nothing is added.
    send_item(frag_item(12'd4095, 4'd1, 1'b1, '1, '1, 6'd63, 12'd10, 1'b0, 1'b0));
    send_item(frag_item(12'd4095, 4'd2, 1'b0, '1, '1, 6'd1, 12'd4095, 1'b0, 1'b1));
    send_item(frag_item(12'd1, 4'd3, 1'b0, a, b, 6'd24, 12'd100, 1'b0, 1'b1));
    send_item(frag_item(12'd5, 4'd0, 1'b1, a, b, 6'd24, 12'd300, 1'b0, 1'b1));
    send_item(frag_item(12'd5, 4'd1, 1'b0, a, b, 6'd24, 12'd300, 1'b0, 1'b0));
    send_item(frag_item(12'd7, 4'd0, 1'b1, a, b, 6'd30, 12'd500, 1'b0, 1'b1));
    send_item(frag_item(12'd8, 4'd0, 1'b0, a, b, 6'd30, 12'd60, 1'b0, 1'b1));
    send_item(frag_item(12'd9, 4'd0, 1'b1, a, b, 6'd30, 12'd500, 1'b0, 1'b1));
    send_item(frag_item(12'd9, 4'd1, 1'b1, a, b, 6'd30, 12'd500, 1'b1, 1'b1));
    send_item(frag_item(12'd10, 4'd0, 1'b1, a, b, 6'd30, 12'd500, 1'b0, 1'b1));
    send_item(frag_item(12'd10, 4'd1, 1'b0, a, b ^ 48'd1, 6'd30, 12'd500, 1'b0, 1'b1));
    send_item(frag_item(12'd11, 4'd0, 1'b1, a, b, 6'd30, 12'd500, 1'b0, 1'b1));
    send_item(frag_item(12'd11, 4'd1, 1'b1, ~a, b, 6'd30, 12'd500, 1'b0, 1'b1));
    send_item(frag_item(12'd12, 4'd0, 1'b1, a, b, 6'd30, 12'd700, 1'b0, 1'b1));
    send_item(frag_item(12'd12, 4'd0, 1'b1, a, b, 6'd30, 12'd800, 1'b0, 1'b1));
    send_item(frag_item(12'd12, 4'd1, 1'b0, a, b, 6'd30, 12'd900, 1'b0, 1'b1));

    write_timeout(16'd0);
    send_item(frag_item(12'd20, 4'd0, 1'b1, a, b, 6'd30, 12'd400, 1'b0, 1'b1));
    send_item(tick_item());
    write_timeout(16'd1);
    send_item(frag_item(12'd21, 4'd0, 1'b1, a, b, 6'd30, 12'd400, 1'b0, 1'b1));
    send_item(tick_item());

    phase_timeouts = '{16'hFFFF, 16'd3, 16'd1, 16'd0, 16'd8, TimeoutReset};
    phase_timeouts[4] = TicksW'($urandom_range(2, 12));
    foreach (phase_timeouts[p]) begin
      write_timeout(phase_timeouts[p]);
      run_random(ItemsPerPhase);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### wlan_defragment_tracker.f
rtl/wdt_pkg.sv
rtl/wdt_in_if.sv
rtl/wdt_out_if.sv
rtl/wdt_apb_regs.sv
rtl/wdt_ctx.sv
rtl/wlan_defragment_tracker.sv
dv/tb_wlan_defragment_tracker.sv
